// File: hdl/sfst_pkg.sv
// Package for the store-and-forward slot table: types, command and event codes,
// register reset values. Used by every module of the block; depends on nothing.
package sfst_pkg;

  // Table geometry.
  localparam int SLOTS  = 8;
  localparam int SLOT_W = $clog2(SLOTS);

  // Command codes.
  localparam logic [1:0] CMD_STORE   = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_DELIVER = 2'd3;

  // Event codes reported in a result word.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_STORED    = 3'd1;
  localparam logic [2:0] EV_ACKED     = 3'd2;
  localparam logic [2:0] EV_EXPIRED   = 3'd3;
  localparam logic [2:0] EV_DELIVERED = 3'd4;
  localparam logic [2:0] EV_RETIRED   = 3'd5;

  // Register indexes; each register sits at byte address 4 * index.
  localparam logic REG_EXPIRE = 1'b0;
  localparam logic REG_RETRY  = 1'b1;

  // Register reset values and the retry counter ceiling.
  localparam logic [31:0] EXPIRE_RESET = 32'd60000;
  localparam logic [3:0]  RETRY_RESET  = 4'd3;
  localparam logic [3:0]  RETRY_MAX    = 4'd15;

  // Input command word.
  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] dest_mac;
    logic [31:0] message_id;
    logic [31:0] now_ms;
    logic        send_ok;
  } sfst_in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  slot;
    logic [31:0] entry_id;
    logic        evicted;
    logic        last;
  } sfst_out_t;

  // One table entry as read out of the table.
  typedef struct packed {
    logic        valid;
    logic [47:0] target;
    logic [31:0] msg_id;
    logic [31:0] stamp;
    logic [3:0]  retries;
  } sfst_entry_t;

  // Write request into the table.
  typedef struct packed {
    logic              store;
    logic              clear;
    logic              bump;
    logic [SLOT_W-1:0] idx;
    logic [47:0]       target;
    logic [31:0]       msg_id;
    logic [31:0]       stamp;
    logic [3:0]        retries;
  } sfst_wr_t;

  // Configuration register values.
  typedef struct packed {
    logic [31:0] expire_ms;
    logic [3:0]  retry_limit;
  } sfst_cfg_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic       older;
    logic       expired;
    logic       key_eq;
    logic       retire;
    logic [3:0] retries_inc;
  } sfst_cmp_t;

endpackage

// File: hdl/sfst_table.sv
// Slot storage of the store-and-forward table: valid bits and entry fields.
// Depends on sfst_pkg for the entry and write request types.
module sfst_table import sfst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] rd_idx,
  output sfst_entry_t       rd,
  input  sfst_wr_t          wr
);

  logic [SLOTS-1:0] valid;
  logic [47:0]      target  [SLOTS];
  logic [31:0]      msg_id  [SLOTS];
  logic [31:0]      stamp   [SLOTS];
  logic [3:0]       retries [SLOTS];

  // Valid bits are the only state cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (wr.store) begin
        valid[wr.idx] <= 1'b1;
      end
      if (wr.clear) begin
        valid[wr.idx] <= 1'b0;
      end
    end
  end

  // Entry fields; a store clears the retry count.
  always_ff @(posedge clk) begin
    if (wr.store) begin
      target[wr.idx]  <= wr.target;
      msg_id[wr.idx]  <= wr.msg_id;
      stamp[wr.idx]   <= wr.stamp;
      retries[wr.idx] <= '0;
    end
    if (wr.bump) begin
      retries[wr.idx] <= wr.retries;
    end
  end

  // The sequencer reads one slot per cycle.
  assign rd.valid   = valid[rd_idx];
  assign rd.target  = target[rd_idx];
  assign rd.msg_id  = msg_id[rd_idx];
  assign rd.stamp   = stamp[rd_idx];
  assign rd.retries = retries[rd_idx];

endmodule

// File: hdl/sfst_cmp.sv
// Shared compare unit: one subtractor for age and oldest-time checks, one key
// comparator for id and address matches, and the retry counter step. Uses sfst_pkg.
module sfst_cmp import sfst_pkg::*; (
  input  logic [1:0]  command,
  input  sfst_in_t    item,
  input  sfst_entry_t entry,
  input  logic [31:0] min_stamp,
  input  sfst_cfg_t   cfg,
  output sfst_cmp_t   res
);

  logic [31:0] sub_a;
  logic [31:0] sub_b;
  logic [32:0] diff;
  logic [47:0] key_a;
  logic [47:0] key_b;

  // Tick computes the wrapped age; store checks the entry time against the minimum.
  always_comb begin
    sub_a = entry.stamp;
    sub_b = min_stamp;
    if (command == CMD_TICK) begin
      sub_a = item.now_ms;
      sub_b = entry.stamp;
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
  end

  // Ack matches on message id, deliver on address.
  always_comb begin
    key_a = item.dest_mac;
    key_b = entry.target;
    if (command == CMD_ACK) begin
      key_a = {16'd0, item.message_id};
      key_b = {16'd0, entry.msg_id};
    end
  end

  assign res.older       = diff[32];
  assign res.expired     = diff[31:0] > cfg.expire_ms;
  assign res.key_eq      = key_a == key_b;
  assign res.retries_inc = (entry.retries == RETRY_MAX) ? RETRY_MAX : entry.retries + 4'd1;
  assign res.retire      = res.retries_inc >= cfg.retry_limit;

endmodule

// File: hdl/sfst_cfg.sv
// Configuration registers of the slot table behind an APB-style port.
// Uses sfst_pkg for the register value type, register indexes and reset values.
module sfst_cfg import sfst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output sfst_cfg_t   cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expire_ms   <= EXPIRE_RESET;
      cfg.retry_limit <= RETRY_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_EXPIRE: cfg.expire_ms <= pwdata;
        REG_RETRY:  cfg.retry_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[2])
      REG_EXPIRE: prdata = cfg.expire_ms;
      REG_RETRY:  prdata = {28'd0, cfg.retry_limit};
      default:    prdata = '0;
    endcase
  end

endmodule

// File: hdl/store_forward_slot_table_core.sv
// Top level of the store-and-forward slot table: command sequencer and result register.
// Instantiates sfst_cfg, sfst_table and sfst_cmp; uses sfst_pkg.
//
// Every command passes through an idle state in which start is taken, a scan state
// that passes the slots one by one through the shared compare unit, and a finish
// state. Results leave as one-cycle
// strobes on result_valid while the scan runs; the last word of a command (last = 1)
// appears in the cycle in which busy falls. The receiver cannot stall, so a word is
// lost unless it is taken in its cycle. A store always yields one word; a command
// that finds nothing to act on yields one word with event 0 and last set.
module store_forward_slot_table_core import sfst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  sfst_in_t    item,
  output logic        result_valid,
  output sfst_out_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  logic [1:0]        state;
  sfst_in_t          cmd_reg;
  logic [SLOT_W-1:0] scan_idx;
  logic              acked;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] min_idx;
  logic [31:0]       min_stamp;
  logic              pend_valid;
  sfst_out_t         pend;

  sfst_cfg_t         cfg;
  sfst_entry_t       rd;
  sfst_wr_t          wr;
  sfst_cmp_t         cmp;
  logic              hit;
  logic [2:0]        hit_ev;
  logic [SLOT_W-1:0] pick_idx;

  sfst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfst_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (scan_idx),
    .rd     (rd),
    .wr     (wr)
  );

  sfst_cmp u_cmp (
    .command   (cmd_reg.command),
    .item      (cmd_reg),
    .entry     (rd),
    .min_stamp (min_stamp),
    .cfg       (cfg),
    .res       (cmp)
  );

  assign busy     = state != ST_IDLE;
  assign pick_idx = free_found ? free_idx : min_idx;

  // Per-slot decision during the scan and the table write it implies.
  always_comb begin
    hit        = 1'b0;
    hit_ev     = EV_NONE;
    wr         = '0;
    wr.idx     = scan_idx;
    wr.target  = cmd_reg.dest_mac;
    wr.msg_id  = cmd_reg.message_id;
    wr.stamp   = cmd_reg.now_ms;
    wr.retries = cmp.retries_inc;
    if (state == ST_SCAN) begin
      unique case (cmd_reg.command)
        CMD_STORE: ;
        CMD_ACK: begin
          if (!acked && rd.valid && cmp.key_eq) begin
            hit      = 1'b1;
            hit_ev   = EV_ACKED;
            wr.clear = 1'b1;
          end
        end
        CMD_TICK: begin
          if (rd.valid && cmp.expired) begin
            hit      = 1'b1;
            hit_ev   = EV_EXPIRED;
            wr.clear = 1'b1;
          end
        end
        CMD_DELIVER: begin
          if (rd.valid && cmp.key_eq) begin
            hit = 1'b1;
            if (!cmd_reg.send_ok) begin
              hit_ev = EV_NONE;
            end else if (cmp.retire) begin
              hit_ev   = EV_RETIRED;
              wr.clear = 1'b1;
            end else begin
              hit_ev  = EV_DELIVERED;
              wr.bump = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (state == ST_FINISH && cmd_reg.command == CMD_STORE) begin
      wr.store = 1'b1;
      wr.idx   = pick_idx;
    end
  end

  // Sequencer. A found event waits in the pending register until the next one
  // or the end of the scan shows whether it is the final word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          result_valid <= 1'b0;
          if (start) begin
            cmd_reg    <= item;
            scan_idx   <= '0;
            acked      <= 1'b0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // A new event pushes the waiting one out as a non-final word.
          result_valid <= hit && pend_valid;
          if (hit) begin
            acked <= 1'b1;
            if (pend_valid) begin
              result <= pend;
            end
            pend.event_res <= hit_ev;
            pend.slot      <= scan_idx;
            pend.entry_id  <= rd.msg_id;
            pend.evicted   <= 1'b0;
            pend.last      <= 1'b0;
            pend_valid     <= 1'b1;
          end
          // Store looks for the first free slot, else the oldest stored time.
          if (cmd_reg.command == CMD_STORE && !free_found) begin
            if (!rd.valid) begin
              free_found <= 1'b1;
              free_idx   <= scan_idx;
            end else if (scan_idx == '0 || cmp.older) begin
              min_idx   <= scan_idx;
              min_stamp <= rd.stamp;
            end
          end
          if (scan_idx == LAST_IDX) begin
            state <= ST_FINISH;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_FINISH: begin
          result_valid <= 1'b1;
          if (cmd_reg.command == CMD_STORE) begin
            result.event_res <= EV_STORED;
            result.slot      <= pick_idx;
            result.entry_id  <= cmd_reg.message_id;
            result.evicted   <= !free_found;
            result.last      <= 1'b1;
          end else if (pend_valid) begin
            result.event_res <= pend.event_res;
            result.slot      <= pend.slot;
            result.entry_id  <= pend.entry_id;
            result.evicted   <= pend.evicted;
            result.last      <= 1'b1;
          end else begin
            result.event_res <= EV_NONE;
            result.slot      <= '0;
            result.entry_id  <= '0;
            result.evicted   <= 1'b0;
            result.last      <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: begin
          result_valid <= 1'b0;
          state        <= ST_IDLE;
        end
      endcase
    end
  end

  // The end of a command always coincides with its final result word.
  a_end_has_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid && result.last)
    else $error("command ended without a final result word");

  // Words that are not final only appear while a command is in progress.
  a_mid_word_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("non-final result word outside a command");

  // A store reports exactly one word.
  a_store_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_res == EV_STORED |-> result.last)
    else $error("store result not marked final");

  // An accepted command starts the scan in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && state == ST_SCAN && scan_idx == '0)
    else $error("accepted command did not start a scan");

endmodule

// File: tb/sv/store_forward_slot_table_core_tb.sv
// Self-checking testbench for store_forward_slot_table_core: command words in,
// result words checked against a table predictor kept in the bench.
// Depends on sfst_pkg and the store_forward_slot_table_core RTL.
module store_forward_slot_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfst_pkg::*;

  localparam logic [2:0] ADDR_EXPIRE = {REG_EXPIRE, 2'b00};
  localparam logic [2:0] ADDR_RETRY  = {REG_RETRY, 2'b00};
  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  sfst_in_t    item = '0;
  logic        result_valid;
  sfst_out_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted table contents and register values.
  logic        tbl_valid   [SLOTS];
  logic [47:0] tbl_target  [SLOTS];
  logic [31:0] tbl_msg_id  [SLOTS];
  logic [31:0] tbl_stamp   [SLOTS];
  logic [3:0]  tbl_retries [SLOTS];
  logic [31:0] cfg_expire = EXPIRE_RESET;
  logic [3:0]  cfg_retry_limit = RETRY_RESET;

  sfst_out_t   pending_events [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic        no_idle = 1'b0;
  logic [31:0] sim_ms = '0;

  store_forward_slot_table_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [31:0] rand32();
    return 32'($urandom());
  endfunction

  function automatic sfst_in_t make_cmd(input logic [1:0] cmd, input logic [47:0] mac,
                                        input logic [31:0] id, input logic [31:0] now,
                                        input logic ok);
    sfst_in_t w;
    w.command    = cmd;
    w.dest_mac   = mac;
    w.message_id = id;
    w.now_ms     = now;
    w.send_ok    = ok;
    return w;
  endfunction

  function automatic sfst_out_t make_event(input logic [2:0] ev, input int idx,
                                           input logic [31:0] id, input logic evict);
    sfst_out_t o;
    o.event_res = ev;
    o.slot      = 3'(idx);
    o.entry_id  = id;
    o.evicted   = evict;
    o.last      = 1'b0;
    return o;
  endfunction

  // Apply one command word to the predicted table and queue the result words it causes.
  task automatic predict_table_events(input sfst_in_t w);
    sfst_out_t   words [$];
    int          i;
    int          pick;
    logic        evict;
    logic        found;
    logic [31:0] age;
    case (w.command)
      CMD_STORE: begin
        pick  = -1;
        evict = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i] && pick < 0) pick = i;
        end
        // A full table gives up the entry with the smallest raw stamp.
        if (pick < 0) begin
          pick = 0;
          for (i = 1; i < SLOTS; i++) begin
            if (tbl_stamp[i] < tbl_stamp[pick]) pick = i;
          end
          evict = 1'b1;
        end
        tbl_valid[pick]   = 1'b1;
        tbl_target[pick]  = w.dest_mac;
        tbl_msg_id[pick]  = w.message_id;
        tbl_stamp[pick]   = w.now_ms;
        tbl_retries[pick] = '0;
        words = {words, make_event(EV_STORED, pick, w.message_id, evict)};
      end
      CMD_ACK: begin
        found = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (!found && tbl_valid[i] && tbl_msg_id[i] == w.message_id) begin
            found = 1'b1;
            tbl_valid[i] = 1'b0;
            words = {words, make_event(EV_ACKED, i, w.message_id, 1'b0)};
          end
        end
      end
      CMD_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          age = w.now_ms - tbl_stamp[i];
          if (tbl_valid[i] && age > cfg_expire) begin
            tbl_valid[i] = 1'b0;
            words = {words, make_event(EV_EXPIRED, i, tbl_msg_id[i], 1'b0)};
          end
        end
      end
      default: begin
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_target[i] == w.dest_mac) begin
            if (!w.send_ok) begin
              words = {words, make_event(EV_NONE, i, tbl_msg_id[i], 1'b0)};
            end else begin
              if (tbl_retries[i] < RETRY_MAX) tbl_retries[i]++;
              if (tbl_retries[i] >= cfg_retry_limit) begin
                tbl_valid[i] = 1'b0;
                words = {words, make_event(EV_RETIRED, i, tbl_msg_id[i], 1'b0)};
              end else begin
                words = {words, make_event(EV_DELIVERED, i, tbl_msg_id[i], 1'b0)};
              end
            end
          end
        end
      end
    endcase
    // A command with nothing to act on still reports one empty word.
    if (words.size() == 0) words = {words, make_event(EV_NONE, 0, '0, 1'b0)};
    words[words.size()-1].last = 1'b1;
    pending_events = {pending_events, words};
  endtask

  // Send one command word, with a random hold-off before start rises.
  task automatic issue_command(input sfst_in_t w);
    int unsigned gap;
    logic        taken;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    // Half the time the gap is counted from the block going idle.
    if (!no_idle && $urandom_range(0, 1) == 1) begin
      @(negedge clk);
      while (busy) @(negedge clk);
    end
    repeat (gap) @(posedge clk);
    @(posedge clk);
    start <= 1'b1;
    item  <= w;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    start <= 1'b0;
    predict_table_events(w);
  endtask

  // Every result word must match the oldest predicted word.
  always @(negedge clk) begin
    sfst_out_t want;
    if (!rst && result_valid) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual ev=%0d slot=%0d id=%08h evicted=%b last=%b",
                 $time, result.event_res, result.slot, result.entry_id, result.evicted,
                 result.last);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (result !== want) begin
          $display("%0t: result mismatch: expected ev=%0d slot=%0d id=%08h evicted=%b last=%b",
                   $time, want.event_res, want.slot, want.entry_id, want.evicted, want.last);
          $display("%0t:                  actual   ev=%0d slot=%0d id=%08h evicted=%b last=%b",
                   $time, result.event_res, result.slot, result.entry_id, result.evicted,
                   result.last);
          mismatch_count++;
        end
      end
    end
  end

  // One register transfer: setup cycle, then access until pready.
  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rd);
    logic done;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      rd   = prdata;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic [2:0] addr, input logic [31:0] want,
                                input logic [31:0] mask);
    logic [31:0] rd;
    reg_access(1'b0, addr, '0, rd);
    if ((rd & mask) !== (want & mask)) begin
      $display("%0t: register %0d read mismatch: expected %08h actual %08h",
               $time, addr, want & mask, rd & mask);
      mismatch_count++;
    end
  endtask

  // Let every predicted word come out and the block fall idle.
  task automatic wait_table_idle();
    while (pending_events.size() != 0) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] expire, input logic [3:0] limit);
    logic [31:0] rd;
    wait_table_idle();
    reg_access(1'b1, ADDR_EXPIRE, expire, rd);
    // Upper bits of the retry word carry noise that the register must drop.
    reg_access(1'b1, ADDR_RETRY, {28'($urandom()), limit}, rd);
    cfg_expire      = expire;
    cfg_retry_limit = limit;
    check_register(ADDR_EXPIRE, expire, 32'hFFFF_FFFF);
    check_register(ADDR_RETRY, {28'd0, limit}, 32'h0000_000F);
  endtask

  task automatic test_register_reset();
    check_register(ADDR_EXPIRE, EXPIRE_RESET, 32'hFFFF_FFFF);
    check_register(ADDR_RETRY, {28'd0, RETRY_RESET}, 32'h0000_000F);
  endtask

  // Directed walk through each command under the reset settings.
  task automatic test_directed_table_ops();
    logic [47:0] mac;
    logic [31:0] id;
    logic [31:0] stamp;
    int          i;
    // Commands on an empty table find nothing.
    issue_command(make_cmd(CMD_TICK, rand48(), rand32(), 32'd0, 1'b1));
    issue_command(make_cmd(CMD_ACK, rand48(), 32'd0, rand32(), 1'b0));
    issue_command(make_cmd(CMD_DELIVER, '1, rand32(), rand32(), 1'b1));
    // Fill the table: extreme addresses and ids, a repeated id, a stamp near the wrap,
    // and two entries sharing the smallest stamp.
    for (i = 0; i < SLOTS; i++) begin
      mac   = (i < 4) ? ((i % 2 == 1) ? '1 : '0) : rand48();
      id    = (i == 0) ? 32'd0 : (i == 1) ? '1 : (i == 2 || i == 5) ? 32'h0000_1234 : rand32();
      stamp = (i == 0) ? 32'd1000 : (i == 1) ? 32'hFFFF_FFF0 :
              (i == 2 || i == 3) ? 32'd500 : 32'd2000 + 32'(i);
      issue_command(make_cmd(CMD_STORE, mac, id, stamp, 1'($urandom())));
    end
    // A full table evicts the oldest stamp, ties to the lowest slot.
    issue_command(make_cmd(CMD_STORE, '0, 32'h0000_1234, 32'd3000, 1'b0));
    // Ack frees only the first entry with a matching id.
    issue_command(make_cmd(CMD_ACK, rand48(), 32'h0000_1234, rand32(), 1'b1));
    issue_command(make_cmd(CMD_ACK, rand48(), '1, rand32(), 1'b0));
    // Failed delivery leaves entries alone; successes count up to retirement.
    issue_command(make_cmd(CMD_DELIVER, '0, rand32(), rand32(), 1'b0));
    repeat (3) issue_command(make_cmd(CMD_DELIVER, '0, rand32(), rand32(), 1'b1));
    // Expiry exactly at the limit does not drop; one past it does.
    issue_command(make_cmd(CMD_TICK, rand48(), rand32(), 32'd61000, 1'b0));
    issue_command(make_cmd(CMD_TICK, rand48(), rand32(), 32'd62005, 1'b1));
    // Store into a freed slot without eviction, then deliver to it.
    issue_command(make_cmd(CMD_STORE, '1, rand32(), 32'd62010, 1'b0));
    issue_command(make_cmd(CMD_DELIVER, '1, rand32(), rand32(), 1'b1));
  endtask

  // Random traffic over small pools of peers and ids so acks and deliveries hit.
  task automatic test_random_traffic(input logic [31:0] expire, input logic [3:0] limit,
                                     input int count);
    logic [47:0] peers [4];
    logic [31:0] ids [6];
    logic [31:0] span;
    logic [31:0] step;
    logic [1:0]  cmd;
    sfst_in_t    w;
    int          k;
    int          r;
    set_config(expire, limit);
    foreach (peers[k]) peers[k] = rand48();
    foreach (ids[k]) ids[k] = rand32();
    // Time advances in steps comparable to the expiry limit.
    span = (expire > 32'd1_000_000) ? 32'd100_000 : expire / 3 + 32'd2;
    for (k = 0; k < count; k++) begin
      if (k % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       step = '0;
        1:       step = rand32();
        default: step = $urandom_range(0, span);
      endcase
      sim_ms += step;
      r = $urandom_range(0, 99);
      cmd = (r < 35) ? CMD_STORE : (r < 55) ? CMD_ACK : (r < 75) ? CMD_TICK : CMD_DELIVER;
      w = make_cmd(cmd, peers[$urandom_range(0, 3)], ids[$urandom_range(0, 5)], sim_ms,
                   $urandom_range(0, 3) != 0);
      r = $urandom_range(0, 19);
      if (r == 0) begin
        w = make_cmd(2'($urandom()), rand48(), rand32(), rand32(), 1'($urandom()));
      end else if (r < 3) begin
        w.dest_mac   = rand48();
        w.message_id = rand32();
      end
      issue_command(w);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_directed_table_ops();
    test_random_traffic(EXPIRE_RESET, RETRY_RESET, 55);
    test_random_traffic(32'd0, 4'd0, 55);
    test_random_traffic(32'hFFFF_FFFF, 4'd15, 55);
    test_random_traffic(32'd1, 4'd1, 55);
    test_random_traffic(rand32(), 4'($urandom_range(1, 15)), 55);
    test_random_traffic(32'd5000, 4'd2, 55);
    test_random_traffic(32'($urandom_range(0, 100000)), 4'($urandom_range(0, 15)), 55);
    test_random_traffic(32'd60000, 4'd3, 55);
    wait_table_idle();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sfst_pkg.sv
hdl/sfst_table.sv
hdl/sfst_cmp.sv
hdl/sfst_cfg.sv
hdl/store_forward_slot_table_core.sv
tb/sv/store_forward_slot_table_core_tb.sv
